### rtl/assert_macros.svh
// Assertion helpers for the plasma pixel block.
// Both macros sample on the rising edge of the signal named clock.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check that is ignored while reset is high.
`define PPC_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("ppc check failed");
// Check that also runs during reset.
`define PPC_ASSERT_RST(lbl, prop) \
   lbl: assert property (@(posedge clock) (prop)) \
      else $error("ppc reset check failed");
`else
`define PPC_ASSERT(lbl, prop)
`define PPC_ASSERT_RST(lbl, prop)
`endif
`endif

### rtl/ppc_pkg.sv
`default_nettype none
package ppc_pkg;

   // Field widths
   localparam int X_W     = 6;
   localparam int Y_W     = 5;
   localparam int T_W     = 20;
   localparam int COLOR_W = 3;

   // Palette size
   localparam int COLORS = 8;

   // Angle (signed Q.12), phase (Q0.16 turns), sine (Q1.14)
   localparam int ANG_W = 25;
   localparam int PH_W  = 16;
   localparam int SIN_W = 16;

   localparam int ONE_Q14 = 16384;
   localparam logic [29:0] INV_TWO_PI = 30'd683565276;
   localparam logic [PH_W-1:0] PH_QUARTER = 16'h4000;

   localparam logic signed [17:0] COEF_A1 = 18'sd25736;
   localparam logic signed [15:0] COEF_A3 = -16'sd10512;
   localparam logic [10:0]        COEF_A5 = 11'd1160;

   // Reciprocal multipliers for t/3 and t/5, both shifted right by DIV_SHIFT
   localparam logic [20:0] DIV3_MUL  = 21'd1398102;
   localparam logic [19:0] DIV5_MUL  = 20'd838861;
   localparam int          DIV_SHIFT = 22;

   // Radicand and root
   localparam int RAD_W = 48;
   localparam int ROOT_W = RAD_W / 2;
   localparam logic [RAD_W-1:0] RAD_BIAS = RAD_W'(1) << 28;

   // Index: floor(n / (3 * 2^15)) as (n * IDX_MUL) >> IDX_SHIFT
   localparam int SUM_BIAS = 3 * ONE_Q14;
   localparam int N_W = 25;
   localparam logic [N_W-1:0] IDX_MUL = 25'd22369622;
   localparam int IDX_SHIFT = 41;
   localparam int IDX_W = 9;

   typedef struct packed {
      logic [1:0]  quad;
      logic [14:0] z;
      logic [14:0] z2;
   } sin_a_type;

   typedef struct packed {
      logic [1:0]         quad;
      logic [14:0]        z;
      logic [14:0]        z2;
      logic signed [15:0] inner;
   } sin_b_type;

   typedef struct packed {
      logic [1:0]  quad;
      logic [14:0] z;
      logic [14:0] poly;
   } sin_c_type;

   // Angle to phase: bits 43..28 of angle * (2^32 / 2pi)
   function automatic logic [PH_W-1:0] phase_of(input logic signed [ANG_W-1:0] ang);
      logic signed [ANG_W+30:0] prod;
      prod = ang * $signed({1'b0, INV_TWO_PI});
      return prod[43:28];
   endfunction

   // Sine step 1: quadrant fold and z^2
   function automatic sin_a_type sin_step_a(input logic [PH_W-1:0] ph);
      sin_a_type r;
      logic [29:0] sq;
      r.quad = ph[15:14];
      r.z = ph[14] ? (15'(ONE_Q14) - {1'b0, ph[13:0]}) : {1'b0, ph[13:0]};
      sq = r.z * r.z;
      r.z2 = sq[28:14];
      return r;
   endfunction

   // Sine step 2: inner = A3 + A5*z^2
   function automatic sin_b_type sin_step_b(input sin_a_type a);
      sin_b_type r;
      logic [25:0] pr;
      pr = a.z2 * COEF_A5;
      r.quad = a.quad;
      r.z = a.z;
      r.z2 = a.z2;
      r.inner = COEF_A3 + $signed({4'b0, pr[25:14]});
      return r;
   endfunction

   // Sine step 3: poly = A1 + floor(inner*z^2)
   function automatic sin_c_type sin_step_c(input sin_b_type b);
      sin_c_type r;
      logic signed [31:0] pr;
      logic signed [17:0] pf;
      pr = b.inner * $signed({1'b0, b.z2});
      pf = COEF_A1 + $signed(pr[31:14]);
      r.quad = b.quad;
      r.z = b.z;
      r.poly = pf[14:0];
      return r;
   endfunction

   // Sine step 4: poly*z, limit, sign
   function automatic logic signed [SIN_W-1:0] sin_step_d(input sin_c_type c);
      logic [29:0] pr;
      logic [15:0] mag;
      logic signed [SIN_W-1:0] s;
      pr = c.poly * c.z;
      mag = pr[29:14];
      if (mag > 16'(ONE_Q14)) begin
         mag = 16'(ONE_Q14);
      end
      s = $signed(mag);
      if (c.quad[1]) begin
         s = -s;
      end
      return s;
   endfunction

endpackage
`default_nettype wire

### rtl/ppc_isqrt.sv
`default_nettype none
module ppc_isqrt (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         enable,
   input  logic                         in_valid,
   input  logic [ppc_pkg::RAD_W-1:0]    in_radicand,
   output logic                         out_valid,
   output logic [ppc_pkg::ROOT_W-1:0]   out_root
);
   import ppc_pkg::*;

   logic                vld_ff  [ROOT_W];
   logic [RAD_W-1:0]    rad_ff  [ROOT_W];
   logic [ROOT_W:0]     rem_ff  [ROOT_W];
   logic [ROOT_W-1:0]   root_ff [ROOT_W];

   logic [RAD_W-1:0]    rad_in  [ROOT_W];
   logic [ROOT_W:0]     rem_in  [ROOT_W];
   logic [ROOT_W-1:0]   root_in [ROOT_W];

   logic [RAD_W-1:0]    src_rad  [ROOT_W];
   logic [ROOT_W:0]     src_rem  [ROOT_W];
   logic [ROOT_W-1:0]   src_root [ROOT_W];
   logic [ROOT_W+2:0]   rem_sh   [ROOT_W];
   logic [ROOT_W+2:0]   trial    [ROOT_W];
   logic [ROOT_W+2:0]   diff     [ROOT_W];

   // One root bit per stage: shift in two radicand bits, try q*4+1
   always_comb begin
      src_rad[0]  = in_radicand;
      src_rem[0]  = '0;
      src_root[0] = '0;
      for (int k = 1; k < ROOT_W; k++) begin
         src_rad[k]  = rad_ff[k-1];
         src_rem[k]  = rem_ff[k-1];
         src_root[k] = root_ff[k-1];
      end
      for (int k = 0; k < ROOT_W; k++) begin
         rem_sh[k] = {src_rem[k], src_rad[k][RAD_W-1 -: 2]};
         trial[k]  = {1'b0, src_root[k], 2'b01};
         diff[k]   = rem_sh[k] - trial[k];
         rad_in[k] = src_rad[k] << 2;
         if (rem_sh[k] >= trial[k]) begin
            rem_in[k]  = diff[k][ROOT_W:0];
            root_in[k] = {src_root[k][ROOT_W-2:0], 1'b1};
         end else begin
            rem_in[k]  = rem_sh[k][ROOT_W:0];
            root_in[k] = {src_root[k][ROOT_W-2:0], 1'b0};
         end
      end
   end

   // Stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < ROOT_W; k++) begin
            vld_ff[k] <= 1'b0;
         end
      end else if (enable) begin
         vld_ff[0] <= in_valid;
         for (int k = 1; k < ROOT_W; k++) begin
            vld_ff[k] <= vld_ff[k-1];
         end
      end
   end

   // Stage payload
   always_ff @(posedge clock) begin
      if (enable) begin
         for (int k = 0; k < ROOT_W; k++) begin
            rad_ff[k]  <= rad_in[k];
            rem_ff[k]  <= rem_in[k];
            root_ff[k] <= root_in[k];
         end
      end
   end

   assign out_valid = vld_ff[ROOT_W-1];
   assign out_root  = root_ff[ROOT_W-1];

endmodule
`default_nettype wire

### rtl/plasma_pixel_color.sv
`default_nettype none
// Channel   Direction  Handshake             Payload
// req_      in         req_valid/req_stall   pixel_x, pixel_y, frame_time
// rsp_      out        rsp_valid/rsp_stall   color_index
//
// One pixel per clock while rsp_stall does not hold the pipeline. A result
// passes the pre stages, the 24-stage square root, the post stages and the output register.
// Reset (synchronous, high) empties every stage; payload is not cleared.
// While a result waits under rsp_stall the whole pipeline holds and
// req_stall is raised; nothing is dropped or repeated.
`include "assert_macros.svh"
module plasma_pixel_color #(
   parameter int COLORS = ppc_pkg::COLORS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [ppc_pkg::X_W-1:0]       req_pixel_x,
   input  logic [ppc_pkg::Y_W-1:0]       req_pixel_y,
   input  logic [ppc_pkg::T_W-1:0]       req_frame_time,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [ppc_pkg::COLOR_W-1:0]   rsp_color_index
);
   import ppc_pkg::*;

   localparam int LANES      = 4;
   localparam int LANE_HALF  = 0;
   localparam int LANE_THIRD = 1;
   localparam int LANE_FIFTH = 2;
   localparam int LANE_V1    = 3;
   localparam int PRE_STAGES  = 9;
   localparam int POST_STAGES = 7;
   // Largest index the output field can show for this palette
   localparam logic [COLOR_W-1:0] INDEX_TOP =
      (COLORS > (1 << COLOR_W)) ? '1 : COLOR_W'(COLORS - 1);

   typedef struct packed {
      logic [X_W-1:0] x;
      logic [Y_W-1:0] y;
      logic [T_W-1:0] t;
   } coord_type;

   typedef struct packed {
      logic [T_W-1:0]          t;
      logic signed [SIN_W-1:0] v1;
      logic [PH_W-1:0]         ph2;
   } side_type;

   logic advance;
   logic [PRE_STAGES-1:0]  stage_vld_ff;
   logic [POST_STAGES-1:0] post_vld_ff;
   logic rsp_valid_ff;
   logic [COLOR_W-1:0] rsp_color_ff;

   // Stage 1
   logic [T_W+20:0] third_prod;
   logic [T_W+19:0] fifth_prod;
   logic signed [ANG_W-1:0] ang1_in;
   coord_type s1_co_ff;
   logic [T_W-2:0] s1_half_ff;
   logic [T_W-2:0] s1_third_ff;
   logic [T_W-3:0] s1_fifth_ff;
   logic signed [ANG_W-1:0] s1_ang1_ff;

   // Stages 2..6: four sine lanes
   logic [PH_W-1:0] s2_ph_ff [LANES];
   coord_type s2_co_ff;
   sin_a_type s3_sin_in [LANES];
   sin_a_type s3_sin_ff [LANES];
   coord_type s3_co_ff;
   sin_b_type s4_sin_in [LANES];
   sin_b_type s4_sin_ff [LANES];
   coord_type s4_co_ff;
   sin_c_type s5_sin_in [LANES];
   sin_c_type s5_sin_ff [LANES];
   coord_type s5_co_ff;
   logic signed [SIN_W-1:0] s6_val_in [LANES];
   logic signed [SIN_W-1:0] s6_val_ff [LANES];
   coord_type s6_co_ff;

   // Stage 7
   logic signed [22:0] p1_in, p2_in;
   logic signed [21:0] cx_in, cy_in;
   logic signed [22:0] s7_p1_ff, s7_p2_ff;
   logic signed [21:0] s7_cx_ff, s7_cy_ff;
   logic [T_W-1:0] s7_t_ff;
   logic signed [SIN_W-1:0] s7_v1_ff;

   // Stage 8
   logic signed [22:0] mix_in;
   logic signed [26:0] mix_ext;
   logic signed [26:0] mix10_in;
   logic signed [ANG_W-1:0] ang2_in;
   logic signed [43:0] cx_sq, cy_sq;
   logic signed [ANG_W-1:0] s8_ang2_ff;
   logic [40:0] s8_cx2_ff, s8_cy2_ff;
   logic [T_W-1:0] s8_t_ff;
   logic signed [SIN_W-1:0] s8_v1_ff;

   // Stage 9
   logic [41:0] sq_sum;
   logic [RAD_W-1:0] rad_in;
   logic [RAD_W-1:0] s9_rad_ff;
   side_type s9_side_ff;

   // Square root and matching delay line
   logic sq_vld;
   logic [ROOT_W-1:0] sq_root;
   side_type dly_ff [ROOT_W];
   side_type dly_out;

   // Post stages
   logic signed [ANG_W-1:0] ang3_in;
   logic signed [ANG_W-1:0] q1_ang3_ff;
   sin_a_type q1_sin2_ff;
   logic signed [SIN_W-1:0] q1_v1_ff;
   logic [PH_W-1:0] q2_ph3_ff;
   sin_b_type q2_sin2_ff;
   logic signed [SIN_W-1:0] q2_v1_ff;
   sin_a_type q3_sin3_ff;
   sin_c_type q3_sin2_ff;
   logic signed [SIN_W-1:0] q3_v1_ff;
   sin_b_type q4_sin3_ff;
   logic signed [SIN_W-1:0] q4_v2_ff, q4_v1_ff;
   sin_c_type q5_sin3_ff;
   logic signed [SIN_W-1:0] q5_v2_ff, q5_v1_ff;
   logic signed [SIN_W-1:0] q6_v3_ff, q6_v2_ff, q6_v1_ff;
   logic signed [18:0] sum_in;
   logic [N_W-1:0] n_in;
   logic [N_W-1:0] q7_n_ff;
   logic [2*N_W-1:0] idx_prod;
   logic [IDX_W-1:0] idx_raw;
   logic [IDX_W-1:0] idx_clamp;

   // Whole pipeline holds while a result waits
   assign advance   = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !advance;

   // Stage 1: time divisions and first angle
   assign third_prod = req_frame_time * DIV3_MUL;
   assign fifth_prod = req_frame_time * DIV5_MUL;
   assign ang1_in = $signed(ANG_W'({req_pixel_x, 15'b0}) + ANG_W'({req_pixel_x, 13'b0})
                            + ANG_W'(req_frame_time));

   // Stages 3..6: sine steps per lane
   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         s3_sin_in[l] = sin_step_a(s2_ph_ff[l]);
         s4_sin_in[l] = sin_step_b(s3_sin_ff[l]);
         s5_sin_in[l] = sin_step_c(s4_sin_ff[l]);
         s6_val_in[l] = sin_step_d(s5_sin_ff[l]);
      end
   end

   // Stage 7: rotation products and ring centers
   assign p1_in = $signed({1'b0, s6_co_ff.x}) * s6_val_ff[LANE_HALF];
   assign p2_in = $signed({1'b0, s6_co_ff.y}) * s6_val_ff[LANE_THIRD];
   assign cx_in = $signed({1'b0, s6_co_ff.x, 14'b0}) + (s6_val_ff[LANE_FIFTH] >>> 1);
   assign cy_in = $signed({1'b0, s6_co_ff.y, 14'b0}) + (s6_val_ff[LANE_THIRD] >>> 1);

   // Stage 8: rotating band angle, squared distances
   assign mix_in   = s7_p1_ff + s7_p2_ff;
   assign mix_ext  = 27'(mix_in);
   assign mix10_in = (mix_ext <<< 3) + (mix_ext <<< 1);
   assign ang2_in  = ANG_W'(mix10_in >>> 2) + $signed(ANG_W'(s7_t_ff));
   assign cx_sq    = s7_cx_ff * s7_cx_ff;
   assign cy_sq    = s7_cy_ff * s7_cy_ff;

   // Stage 9: radicand 100*(cx^2+cy^2)+1 in Q.28
   assign sq_sum = {1'b0, s8_cx2_ff} + {1'b0, s8_cy2_ff};
   assign rad_in = (RAD_W'(sq_sum) << 6) + (RAD_W'(sq_sum) << 5) + (RAD_W'(sq_sum) << 2)
                 + RAD_BIAS;

   ppc_isqrt u_isqrt (
      .clock       (clock),
      .reset       (reset),
      .enable      (advance),
      .in_valid    (stage_vld_ff[PRE_STAGES-1]),
      .in_radicand (s9_rad_ff),
      .out_valid   (sq_vld),
      .out_root    (sq_root)
   );

   assign dly_out = dly_ff[ROOT_W-1];

   // Ring angle
   assign ang3_in = $signed(ANG_W'(sq_root[ROOT_W-1:2]) + ANG_W'(dly_out.t));

   // Final sum and palette scale
   assign sum_in = 19'(q6_v1_ff) + 19'(q6_v2_ff) + 19'(q6_v3_ff) + 19'(SUM_BIAS);
   assign n_in   = N_W'(sum_in[16:0]) * N_W'(COLORS);
   assign idx_prod  = q7_n_ff * IDX_MUL;
   assign idx_raw   = idx_prod[IDX_SHIFT+IDX_W-1:IDX_SHIFT];
   assign idx_clamp = (idx_raw > IDX_W'(COLORS - 1)) ? IDX_W'(COLORS - 1) : idx_raw;

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_vld_ff <= '0;
         post_vld_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         stage_vld_ff <= {stage_vld_ff[PRE_STAGES-2:0], req_valid};
         post_vld_ff  <= {post_vld_ff[POST_STAGES-2:0], sq_vld};
         rsp_valid_ff <= post_vld_ff[POST_STAGES-1];
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (advance) begin
         s1_co_ff.x  <= req_pixel_x;
         s1_co_ff.y  <= req_pixel_y;
         s1_co_ff.t  <= req_frame_time;
         s1_half_ff  <= req_frame_time[T_W-1:1];
         s1_third_ff <= third_prod[DIV_SHIFT+T_W-2:DIV_SHIFT];
         s1_fifth_ff <= fifth_prod[DIV_SHIFT+T_W-3:DIV_SHIFT];
         s1_ang1_ff  <= ang1_in;

         s2_ph_ff[LANE_HALF]  <= phase_of($signed(ANG_W'(s1_half_ff)));
         s2_ph_ff[LANE_THIRD] <= phase_of($signed(ANG_W'(s1_third_ff))) + PH_QUARTER;
         s2_ph_ff[LANE_FIFTH] <= phase_of($signed(ANG_W'(s1_fifth_ff)));
         s2_ph_ff[LANE_V1]    <= phase_of(s1_ang1_ff);
         s2_co_ff <= s1_co_ff;

         for (int l = 0; l < LANES; l++) begin
            s3_sin_ff[l] <= s3_sin_in[l];
            s4_sin_ff[l] <= s4_sin_in[l];
            s5_sin_ff[l] <= s5_sin_in[l];
            s6_val_ff[l] <= s6_val_in[l];
         end
         s3_co_ff <= s2_co_ff;
         s4_co_ff <= s3_co_ff;
         s5_co_ff <= s4_co_ff;
         s6_co_ff <= s5_co_ff;

         s7_p1_ff <= p1_in;
         s7_p2_ff <= p2_in;
         s7_cx_ff <= cx_in;
         s7_cy_ff <= cy_in;
         s7_t_ff  <= s6_co_ff.t;
         s7_v1_ff <= s6_val_ff[LANE_V1];

         s8_ang2_ff <= ang2_in;
         s8_cx2_ff  <= cx_sq[40:0];
         s8_cy2_ff  <= cy_sq[40:0];
         s8_t_ff    <= s7_t_ff;
         s8_v1_ff   <= s7_v1_ff;

         s9_rad_ff      <= rad_in;
         s9_side_ff.t   <= s8_t_ff;
         s9_side_ff.v1  <= s8_v1_ff;
         s9_side_ff.ph2 <= phase_of(s8_ang2_ff);

         dly_ff[0] <= s9_side_ff;
         for (int k = 1; k < ROOT_W; k++) begin
            dly_ff[k] <= dly_ff[k-1];
         end

         q1_ang3_ff <= ang3_in;
         q1_sin2_ff <= sin_step_a(dly_out.ph2);
         q1_v1_ff   <= dly_out.v1;

         q2_ph3_ff  <= phase_of(q1_ang3_ff);
         q2_sin2_ff <= sin_step_b(q1_sin2_ff);
         q2_v1_ff   <= q1_v1_ff;

         q3_sin3_ff <= sin_step_a(q2_ph3_ff);
         q3_sin2_ff <= sin_step_c(q2_sin2_ff);
         q3_v1_ff   <= q2_v1_ff;

         q4_sin3_ff <= sin_step_b(q3_sin3_ff);
         q4_v2_ff   <= sin_step_d(q3_sin2_ff);
         q4_v1_ff   <= q3_v1_ff;

         q5_sin3_ff <= sin_step_c(q4_sin3_ff);
         q5_v2_ff   <= q4_v2_ff;
         q5_v1_ff   <= q4_v1_ff;

         q6_v3_ff <= sin_step_d(q5_sin3_ff);
         q6_v2_ff <= q5_v2_ff;
         q6_v1_ff <= q5_v1_ff;

         q7_n_ff <= n_in;

         rsp_color_ff <= idx_clamp[COLOR_W-1:0];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_color_index = rsp_color_ff;

   `PPC_ASSERT_RST(a_reset_empties, reset |=> (!rsp_valid && stage_vld_ff == '0))
   `PPC_ASSERT(a_frozen_holds, !advance |=> ($stable(stage_vld_ff) && $stable(post_vld_ff)))
   `PPC_ASSERT(a_rsp_from_pipe, $rose(rsp_valid) |-> $past(post_vld_ff[POST_STAGES-1]))
   `PPC_ASSERT(a_index_in_palette, rsp_valid |-> (rsp_color_index <= INDEX_TOP))

endmodule
`default_nettype wire
